// File: hw/rtl/ola_pkg.sv
// ----------------------------------------------------------------------------
// ola_pkg
// Shared widths, command codes, status codes and cell operation codes for the
// ordered array list engine.
// ----------------------------------------------------------------------------
package ola_pkg;

  // item field widths
  localparam int CMD_W   = 3;
  localparam int POS_W   = 7;
  localparam int OPOS_W  = 6;
  localparam int VAL_W   = 32;
  localparam int FPOS_W  = 6;
  localparam int CNTO_W  = 7;
  localparam int STAT_W  = 2;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] stat_t;
  typedef logic [2:0]        cell_op_t;

  // commands
  localparam cmd_t CMD_APPEND  = 3'd0;
  localparam cmd_t CMD_INSERT  = 3'd1;
  localparam cmd_t CMD_REM_AT  = 3'd2;
  localparam cmd_t CMD_REM_VAL = 3'd3;
  localparam cmd_t CMD_READ    = 3'd4;
  localparam cmd_t CMD_WRITE   = 3'd5;
  localparam cmd_t CMD_FIND    = 3'd6;
  localparam cmd_t CMD_SWAP    = 3'd7;

  // status
  localparam stat_t ST_OK      = 2'd0;
  localparam stat_t ST_FULL    = 2'd1;
  localparam stat_t ST_BAD_POS = 2'd2;
  localparam stat_t ST_MISSING = 2'd3;

  // operations broadcast along the cell row
  localparam cell_op_t CELL_HOLD   = 3'd0;
  localparam cell_op_t CELL_LOOK   = 3'd1;
  localparam cell_op_t CELL_APPEND = 3'd2;
  localparam cell_op_t CELL_INSERT = 3'd3;
  localparam cell_op_t CELL_REMOVE = 3'd4;
  localparam cell_op_t CELL_WRITE  = 3'd5;
  localparam cell_op_t CELL_SWAP   = 3'd6;

endpackage

// File: hw/rtl/ola_if.sv
// ----------------------------------------------------------------------------
// ola_in_if / ola_out_if
// Valid/ready channels carrying command items in and result items out.
// ----------------------------------------------------------------------------
interface ola_in_if;
  logic                                valid;
  logic                                ready;
  logic [ola_pkg::CMD_W-1:0]           command;
  logic [ola_pkg::POS_W-1:0]           position;
  logic [ola_pkg::OPOS_W-1:0]          other_position;
  logic signed [ola_pkg::VAL_W-1:0]    value;

  modport source (output valid, command, position, other_position, value, input ready);
  modport sink   (input valid, command, position, other_position, value, output ready);
endinterface

interface ola_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ola_pkg::VAL_W-1:0]    read_value;
  logic [ola_pkg::FPOS_W-1:0]          found_position;
  logic                                found;
  logic [ola_pkg::CNTO_W-1:0]          entry_count;
  logic [ola_pkg::STAT_W-1:0]          status;

  modport source (output valid, read_value, found_position, found, entry_count, status,
                  input ready);
  modport sink   (input valid, read_value, found_position, found, entry_count, status,
                  output ready);
endinterface

// File: hw/rtl/ola_cell.sv
// ----------------------------------------------------------------------------
// ola_cell
// One list slot: holds a word, compares it against the search value, taps it
// out for reads and swaps, and shifts to or from its neighbors.
// ----------------------------------------------------------------------------
module ola_cell #(
  parameter int DW = 32,
  parameter int PW = 7
) (
  input  logic                   clk,
  input  ola_pkg::cell_op_t      op,
  input  logic [PW-1:0]          idx,
  input  logic [PW-1:0]          cnt,
  input  logic [PW-1:0]          pos_a,
  input  logic [PW-1:0]          pos_b,
  input  logic [DW-1:0]          value,
  input  logic [DW-1:0]          data_a,
  input  logic [DW-1:0]          data_b,
  input  logic [DW-1:0]          left,
  input  logic [DW-1:0]          right,
  output logic [DW-1:0]          data_o,
  output logic                   match_o,
  output logic [DW-1:0]          tap_a_o,
  output logic [DW-1:0]          tap_b_o
);
  import ola_pkg::*;

  logic [DW-1:0] data_r;
  logic          match_r;
  logic [DW-1:0] tap_a_r;
  logic [DW-1:0] tap_b_r;
  logic          in_use;
  logic          below_last;

  assign in_use     = idx < cnt;
  // idx + 1 < cnt, kept one bit wider
  assign below_last = ({1'b0, idx} + {{PW{1'b0}}, 1'b1}) < {1'b0, cnt};

  always_ff @(posedge clk) begin
    case (op)
      CELL_LOOK: begin
        match_r <= in_use && (data_r == value);
        tap_a_r <= (idx == pos_a) ? data_r : '0;
        tap_b_r <= (idx == pos_b) ? data_r : '0;
      end
      CELL_APPEND: begin
        if (idx == cnt) data_r <= value;
      end
      CELL_INSERT: begin
        if (idx == pos_a) begin
          data_r <= value;
        end else if (idx > pos_a && idx <= cnt) begin
          data_r <= left;
        end
      end
      CELL_REMOVE: begin
        if (idx >= pos_a && below_last) data_r <= right;
      end
      CELL_WRITE: begin
        if (idx == pos_a) data_r <= value;
      end
      CELL_SWAP: begin
        if (idx == pos_a) begin
          data_r <= data_b;
        end else if (idx == pos_b) begin
          data_r <= data_a;
        end
      end
      default: begin
      end
    endcase
  end

  assign data_o  = data_r;
  assign match_o = match_r;
  assign tap_a_o = tap_a_r;
  assign tap_b_o = tap_b_r;

endmodule

// File: hw/rtl/ordered_array_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// Ordered list of signed words kept in a row of cells, one word per cell,
// with append, insert, remove, search, read, write and swap commands.
// ----------------------------------------------------------------------------
// usage:
//   in_ch  : one command item per handshake (command, position,
//            other_position, value); taken when valid and ready are high
//   out_ch : exactly one result item per command, in command order
//   flow   : an accepted item passes the LOOK, RESOLVE and APPLY states;
//            the next item is taken only once the sequencer is back in IDLE
//   row    : the cell row pass has these steps: all cells compare and tap,
//            the match and tap vectors are reduced, and the shift or write
//            is applied across the whole row
//   stalls : the result sits in an output register; the next item is
//            accepted while it waits, and its own result is held in the
//            row until the output register frees up
//   reset  : the count goes to zero and both channels go quiet; the
//            stored words are not cleared (only slots below the count
//            are ever read)
// ----------------------------------------------------------------------------
module ordered_array_list_engine #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  ola_in_if.sink            in_ch,
  ola_out_if.source         out_ch
);
  import ola_pkg::*;

  // position/count width: covers the 7-bit position field and DEPTH itself
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int DW = DATA_WIDTH;

  // sequencer states
  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_LOOK    = 2'd1;
  localparam logic [1:0] S_RESOLVE = 2'd2;
  localparam logic [1:0] S_APPLY   = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [PW-1:0] count_r, count_nxt;

  // captured command item
  cmd_t          cmd_r;
  logic [PW-1:0] pos_r;
  logic [PW-1:0] pos2_r;
  logic [DW-1:0] val_r;
  logic [63:0]   val_ext;

  // reduced row results
  logic          any_r;
  logic [PW-1:0] fpos_r;
  logic [DW-1:0] rd_a_r;
  logic [DW-1:0] rd_b_r;
  logic          any_nxt;
  logic [PW-1:0] fpos_nxt;
  logic [DW-1:0] rd_a_nxt;
  logic [DW-1:0] rd_b_nxt;

  // output register
  logic                 out_valid_r;
  logic [VAL_W-1:0]     out_rd_r;
  logic [FPOS_W-1:0]    out_fpos_r;
  logic                 out_found_r;
  logic [CNTO_W-1:0]    out_cnt_r;
  stat_t                out_st_r;

  // row wiring
  cell_op_t       row_op;
  logic [PW-1:0]  row_pos_a;
  logic [DW-1:0]  cell_data  [DEPTH];
  logic [DW-1:0]  cell_tap_a [DEPTH];
  logic [DW-1:0]  cell_tap_b [DEPTH];
  logic [DEPTH-1:0] cell_match;

  // apply-stage decision
  logic      commit;
  cell_op_t  apply_op;
  stat_t     apply_st;
  logic      apply_found;
  logic      full;
  logic [63:0] rd_ext;

  logic in_accept;
  assign in_accept = in_ch.valid && in_ch.ready;
  // no item is taken while reset is held
  assign in_ch.ready = rst_n && (state_r == S_IDLE);

  // value is sign-extended, then kept to its low DATA_WIDTH bits
  assign val_ext = 64'(in_ch.value);

  // result can leave the row once the output register is free
  assign commit = (state_r == S_APPLY) && (!out_valid_r || out_ch.ready);

  // ---------------------------------------------------------------------------
  // cell row
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DW-1:0] left_w;
    logic [DW-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    ola_cell #(.DW(DW), .PW(PW)) u_cell (
      .clk     (clk),
      .op      (row_op),
      .idx     (PW'(i)),
      .cnt     (count_r),
      .pos_a   (row_pos_a),
      .pos_b   (pos2_r),
      .value   (val_r),
      .data_a  (rd_a_r),
      .data_b  (rd_b_r),
      .left    (left_w),
      .right   (right_w),
      .data_o  (cell_data[i]),
      .match_o (cell_match[i]),
      .tap_a_o (cell_tap_a[i]),
      .tap_b_o (cell_tap_b[i])
    );
  end

  // ---------------------------------------------------------------------------
  // reduce matches and taps (one registered level)
  // ---------------------------------------------------------------------------
  always_comb begin
    any_nxt  = |cell_match;
    fpos_nxt = '0;
    rd_a_nxt = '0;
    rd_b_nxt = '0;
    // lowest matching slot wins
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i]) fpos_nxt = PW'(i);
    end
    for (int i = 0; i < DEPTH; i++) begin
      rd_a_nxt = rd_a_nxt | cell_tap_a[i];
      rd_b_nxt = rd_b_nxt | cell_tap_b[i];
    end
  end

  // ---------------------------------------------------------------------------
  // command decode in the apply stage
  // ---------------------------------------------------------------------------
  assign full = (count_r == PW'(DEPTH));

  always_comb begin
    apply_op    = CELL_HOLD;
    apply_st    = ST_OK;
    apply_found = 1'b0;
    count_nxt   = count_r;
    case (cmd_r)
      CMD_APPEND: begin
        if (full) begin
          apply_st = ST_FULL;
        end else begin
          apply_op  = CELL_APPEND;
          count_nxt = count_r + PW'(1);
        end
      end
      CMD_INSERT: begin
        if (full) begin
          apply_st = ST_FULL;
        end else if (pos_r > count_r) begin
          apply_st = ST_BAD_POS;
        end else begin
          apply_op  = CELL_INSERT;
          count_nxt = count_r + PW'(1);
        end
      end
      CMD_REM_AT: begin
        if (pos_r >= count_r) begin
          apply_st = ST_BAD_POS;
        end else begin
          apply_op  = CELL_REMOVE;
          count_nxt = count_r - PW'(1);
        end
      end
      CMD_REM_VAL: begin
        if (!any_r) begin
          apply_st = ST_MISSING;
        end else begin
          apply_found = 1'b1;
          apply_op    = CELL_REMOVE;
          count_nxt   = count_r - PW'(1);
        end
      end
      CMD_READ: begin
        if (pos_r >= count_r) apply_st = ST_BAD_POS;
      end
      CMD_WRITE: begin
        if (pos_r >= count_r) begin
          apply_st = ST_BAD_POS;
        end else begin
          apply_op = CELL_WRITE;
        end
      end
      CMD_FIND: begin
        if (!any_r) begin
          apply_st = ST_MISSING;
        end else begin
          apply_found = 1'b1;
        end
      end
      CMD_SWAP: begin
        if (pos_r >= count_r || pos2_r >= count_r) begin
          apply_st = ST_BAD_POS;
        end else begin
          apply_op = CELL_SWAP;
        end
      end
      default: begin
        apply_st = ST_BAD_POS;
      end
    endcase
  end

  // row broadcast: compare pass in LOOK, update only when the result commits
  always_comb begin
    row_op    = CELL_HOLD;
    row_pos_a = pos_r;
    if (state_r == S_LOOK) begin
      row_op = CELL_LOOK;
    end else if (commit) begin
      row_op = apply_op;
      // remove by value shifts down from the matched slot
      if (cmd_r == CMD_REM_VAL) row_pos_a = fpos_r;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_accept) state_nxt = S_LOOK;
      S_LOOK:    state_nxt = S_RESOLVE;
      S_RESOLVE: state_nxt = S_APPLY;
      S_APPLY:   if (commit) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // captured item and reduced row data
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= in_ch.command;
      pos_r  <= PW'(in_ch.position);
      pos2_r <= PW'(in_ch.other_position);
      val_r  <= val_ext[DW-1:0];
    end
    if (state_r == S_RESOLVE) begin
      any_r  <= any_nxt;
      fpos_r <= fpos_nxt;
      rd_a_r <= rd_a_nxt;
      rd_b_r <= rd_b_nxt;
    end
  end

  // read data comes back zero-extended from DATA_WIDTH bits
  assign rd_ext = 64'(rd_a_r);

  always_ff @(posedge clk) begin
    if (commit) begin
      out_rd_r    <= (cmd_r == CMD_READ && apply_st == ST_OK) ? rd_ext[VAL_W-1:0] : '0;
      out_fpos_r  <= apply_found ? fpos_r[FPOS_W-1:0] : '0;
      out_found_r <= apply_found;
      out_cnt_r   <= count_nxt[CNTO_W-1:0];
      out_st_r    <= apply_st;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_value     = out_rd_r;
  assign out_ch.found_position = out_fpos_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.entry_count    = out_cnt_r;
  assign out_ch.status         = out_st_r;

endmodule

// File: hw/rtl/ola_checker.sv
// ----------------------------------------------------------------------------
// ola_checker
// Port-level checks for the ordered array list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ola_checker #(
  parameter int DEPTH = 64
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ola_pkg::VAL_W-1:0]    out_read_value,
  input logic [ola_pkg::FPOS_W-1:0]   out_found_position,
  input logic                         out_found,
  input logic [ola_pkg::CNTO_W-1:0]   out_entry_count,
  input logic [ola_pkg::STAT_W-1:0]   out_status
);
  import ola_pkg::*;

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value)
      && $stable(out_status) && $stable(out_entry_count))
    else $error("result changed while stalled");

  // one item in flight: no second accept right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous still in work");

  // a match is only reported on success
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK)
    else $error("found flag with failing status");

  // failed commands report no data
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_read_value == '0
      && out_found_position == '0 && !out_found)
    else $error("failing command reported data");

  // count stays within the store
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_entry_count) <= 32'(DEPTH))
    else $error("entry count beyond depth");

endmodule

bind ordered_array_list_engine ola_checker #(.DEPTH(DEPTH)) u_ola_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_read_value     (out_ch.read_value),
  .out_found_position (out_ch.found_position),
  .out_found          (out_ch.found),
  .out_entry_count    (out_ch.entry_count),
  .out_status         (out_ch.status)
);
